[design/hsvrb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrb_pkg
// shared types, constants and scaling helpers for the rainbow hsv to rgb core
// ----------------------------------------------------------------------------
package hsvrb_pkg;

   localparam logic [7:0] CH_MAX      = 8'hFF;
   localparam logic [7:0] THIRD_SCALE = 8'(256 / 3);
   localparam logic [7:0] TWO3_SCALE  = 8'((256 * 2) / 3);
   localparam logic [7:0] LVL_85      = 8'd85;
   localparam logic [7:0] LVL_170     = 8'd170;
   localparam logic [7:0] LVL_171     = 8'd171;

   // hue sectors from the top three hue bits
   typedef enum logic [2:0] {
      SECT_RED    = 3'd0,
      SECT_ORANGE = 3'd1,
      SECT_YELLOW = 3'd2,
      SECT_GREEN  = 3'd3,
      SECT_AQUA   = 3'd4,
      SECT_BLUE   = 3'd5,
      SECT_PURPLE = 3'd6,
      SECT_PINK   = 3'd7
   } sector_type;

   typedef logic [2:0][7:0] rgb_type;

   // after hue map, before desaturation
   typedef struct packed {
      rgb_type    ch;
      logic [7:0] d;
      logic       sat_full;
      logic       sat_zero;
      logic [7:0] brightness;
   } hue_beat_type;

   // after desaturation, before value scaling
   typedef struct packed {
      rgb_type    ch;
      logic [7:0] v;
      logic       val_full;
   } sat_beat_type;

   function automatic logic [7:0] scale8(input logic [7:0] i, input logic [7:0] s);
      logic [15:0] prod;
      prod = 16'(i) * 16'(s);
      return prod[15:8];
   endfunction

   // as scale8, plus one when both inputs are nonzero, so a nonzero product never rounds down to zero
   function automatic logic [7:0] scale8_floor(input logic [7:0] i, input logic [7:0] s);
      logic [15:0] prod;
      prod = 16'(i) * 16'(s);
      return prod[15:8] + 8'((i != 8'd0) && (s != 8'd0));
   endfunction

endpackage

[design/hsvrb_hue_stage.sv]
// ----------------------------------------------------------------------------
// hsvrb_hue_stage
// first stage: sector map with third ramps, and the desaturation level
// ----------------------------------------------------------------------------
module hsvrb_hue_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_stall,
   input  logic [7:0]           hue,
   input  logic [7:0]           saturation,
   input  logic [7:0]           brightness,
   output logic                 dn_valid,
   input  logic                 dn_stall,
   output hsvrb_pkg::hue_beat_type dn_beat
);
   import hsvrb_pkg::*;

   logic         valid_ff, valid_in;
   hue_beat_type beat_ff, beat_in;
   logic [7:0]   pos8, third, two3, sat_inv;
   logic         advance;

   assign up_stall = valid_ff && dn_stall;
   assign advance  = !up_stall;

   always_comb begin
      pos8    = {hue[4:0], 3'b000};
      third   = scale8(pos8, THIRD_SCALE);
      two3    = scale8(pos8, TWO3_SCALE);
      sat_inv = ~saturation;
      beat_in = '0;
      unique case (sector_type'(hue[7:5]))
         SECT_RED: begin
            beat_in.ch = {8'd0, third, CH_MAX - third};
         end
         SECT_ORANGE: begin
            beat_in.ch = {8'd0, LVL_85 + third, LVL_171};
         end
         SECT_YELLOW: begin
            beat_in.ch = {8'd0, LVL_170 + third, LVL_171 - two3};
         end
         SECT_GREEN: begin
            beat_in.ch = {third, CH_MAX - third, 8'd0};
         end
         SECT_AQUA: begin
            beat_in.ch = {LVL_85 + two3, LVL_171 - two3, 8'd0};
         end
         SECT_BLUE: begin
            beat_in.ch = {CH_MAX - third, 8'd0, third};
         end
         SECT_PURPLE: begin
            beat_in.ch = {LVL_171 - third, 8'd0, LVL_85 + third};
         end
         SECT_PINK: begin
            beat_in.ch = {LVL_85 - third, 8'd0, LVL_170 + third};
         end
      endcase
      beat_in.d          = scale8_floor(sat_inv, sat_inv);
      beat_in.sat_full   = (saturation == CH_MAX);
      beat_in.sat_zero   = (saturation == 8'd0);
      beat_in.brightness = brightness;
      valid_in           = advance ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

[design/hsvrb_sat_stage.sv]
// ----------------------------------------------------------------------------
// hsvrb_sat_stage
// second stage: blend toward white, and the squared value level
// ----------------------------------------------------------------------------
module hsvrb_sat_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  hsvrb_pkg::hue_beat_type up_beat,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output hsvrb_pkg::sat_beat_type dn_beat
);
   import hsvrb_pkg::*;

   logic         valid_ff, valid_in;
   sat_beat_type beat_ff, beat_in;
   logic [7:0]   keep, kept;
   logic         advance;

   assign up_stall = valid_ff && dn_stall;
   assign advance  = !up_stall;

   always_comb begin
      keep    = ~up_beat.d;
      beat_in = '0;
      for (int k = 0; k < 3; k++) begin
         kept = (up_beat.ch[k] != 8'd0) ? scale8(up_beat.ch[k], keep) + 8'd1 : 8'd0;
         priority if (up_beat.sat_full) begin
            beat_in.ch[k] = up_beat.ch[k];
         end else if (up_beat.sat_zero) begin
            beat_in.ch[k] = CH_MAX;
         end else begin
            beat_in.ch[k] = kept + up_beat.d;
         end
      end
      beat_in.v        = scale8_floor(up_beat.brightness, up_beat.brightness);
      beat_in.val_full = (up_beat.brightness == CH_MAX);
      valid_in         = advance ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

[design/hsvrb_val_stage.sv]
// ----------------------------------------------------------------------------
// hsvrb_val_stage
// third stage: value scaling into the output register
// ----------------------------------------------------------------------------
module hsvrb_val_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  hsvrb_pkg::sat_beat_type up_beat,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output hsvrb_pkg::rgb_type      dn_rgb
);
   import hsvrb_pkg::*;

   logic    valid_ff, valid_in;
   rgb_type rgb_ff, rgb_in;
   logic    advance;

   assign up_stall = valid_ff && dn_stall;
   assign advance  = !up_stall;

   always_comb begin
      rgb_in = '0;
      for (int k = 0; k < 3; k++) begin
         priority if (up_beat.val_full) begin
            rgb_in[k] = up_beat.ch[k];
         end else if ((up_beat.v == 8'd0) || (up_beat.ch[k] == 8'd0)) begin
            rgb_in[k] = 8'd0;
         end else begin
            rgb_in[k] = scale8(up_beat.ch[k], up_beat.v) + 8'd1;
         end
      end
      valid_in = advance ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         rgb_ff <= rgb_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rgb   = rgb_ff;

endmodule

[design/hsv_rainbow_to_rgb_core.sv]
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_core
// 8-bit hsv to rgb colour conversion over the rainbow hue map, three stages
// ----------------------------------------------------------------------------
//
//   channel  ports                                     direction
//   req      req_valid req_stall req_hue/saturation/    in  (stall out)
//            req_brightness
//   rsp      rsp_valid rsp_stall rsp_red/green/blue     out (stall in)
//
// one beat enters per clock while req_stall is low; a result passes the hue, sat and val registers
// the depth is set by the three multiply stages: hue ramps, desaturation, value
// reset clears the stage valid bits only; the data registers need none
// a stall on rsp holds each full stage and only backs up into req_stall
// once the stage in front of it is full, so bubbles are squeezed out
//
module hsv_rainbow_to_rgb_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import hsvrb_pkg::*;

   // stage one to two
   logic         hue_valid, hue_stall;
   hue_beat_type hue_beat;
   // stage two to three
   logic         sat_valid, sat_stall;
   sat_beat_type sat_beat;
   // output register
   rgb_type      out_rgb;

   // sector map, ramps and desaturation level
   hsvrb_hue_stage u_hue (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_stall   (req_stall),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .dn_valid   (hue_valid),
      .dn_stall   (hue_stall),
      .dn_beat    (hue_beat)
   );

   // blend toward white with the video floor
   hsvrb_sat_stage u_sat (
      .clock    (clock),
      .reset    (reset),
      .up_valid (hue_valid),
      .up_stall (hue_stall),
      .up_beat  (hue_beat),
      .dn_valid (sat_valid),
      .dn_stall (sat_stall),
      .dn_beat  (sat_beat)
   );

   // squared value scaling, last stage doubles as the output register
   hsvrb_val_stage u_val (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sat_valid),
      .up_stall (sat_stall),
      .up_beat  (sat_beat),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_rgb   (out_rgb)
   );

   assign rsp_red   = out_rgb[0];
   assign rsp_green = out_rgb[1];
   assign rsp_blue  = out_rgb[2];

   // pipeline empty right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !hue_valid && !sat_valid)
      else $error("pipeline not empty after reset");

   // a draining output never pushes back on the input
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   // a full, blocked pipeline must push back on the input
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (hue_valid && sat_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while every stage is full and blocked");

   // an input stall only happens with every stage full and the output stalled
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> hue_valid && sat_valid && rsp_valid && rsp_stall)
      else $error("input stalled with a free stage");

endmodule
